// File: rtl/ncpb_pkg.sv
// Package: widths, constants and shared types of the normalized cross power bin block.
package ncpb_pkg;

  // Field widths
  localparam int SPEC_W   = 18;
  localparam int OUT_FRAC = 15;
  localparam int WT_W     = 17;
  localparam int WT_FRAC  = 16;
  localparam int OUT_W    = OUT_FRAC + 1;

  // Cross power and normalization
  localparam int PROD_W  = 2 * SPEC_W;
  localparam int CPX_W   = 2 * SPEC_W + 1;
  localparam int CMAG_W  = 2 * SPEC_W;
  localparam int NRM_W   = 30;
  localparam int NRM_MSB = NRM_W - 1;
  localparam int SH_W    = $clog2(CMAG_W + NRM_W);
  localparam int POS_W   = $clog2(CMAG_W);

  // Magnitude
  localparam int SQ_W  = 2 * NRM_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int SQR_W = SUM_W + 1;
  localparam int NSQ   = (SUM_W + 1) / 2;
  localparam int MAG_W = NRM_W + 1;

  // Division
  localparam int NUM_SH = (OUT_FRAC >= WT_FRAC) ? (OUT_FRAC - WT_FRAC) : 0;
  localparam int DEN_SH = (OUT_FRAC < WT_FRAC) ? (WT_FRAC - OUT_FRAC) : 0;
  localparam int NUM_W  = NRM_W + WT_W;
  localparam int DEN_W  = MAG_W + DEN_SH;
  localparam int QW     = OUT_FRAC + 2;
  localparam int DW_A   = NUM_W + NUM_SH + 1;
  localparam int DW_B   = DEN_W + QW - 1;
  localparam int DW     = (DW_A > DW_B) ? DW_A : DW_B;

  localparam logic [QW-1:0] LIMIT = QW'((64'd1 << OUT_FRAC) - 64'd1);

  typedef struct packed {
    logic zero;
    logic neg_r;
    logic neg_i;
  } ncpb_flag_t;

  typedef struct packed {
    ncpb_flag_t       flags;
    logic [NUM_W-1:0] num_r;
    logic [NUM_W-1:0] num_i;
  } ncpb_side_t;

endpackage

// File: rtl/ncpb_if.sv
// Interfaces: bin request channel and result channel.
interface ncpb_in_if;
  import ncpb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [SPEC_W-1:0] first_real;
  logic signed [SPEC_W-1:0] first_imag;
  logic signed [SPEC_W-1:0] second_real;
  logic signed [SPEC_W-1:0] second_imag;
  logic [WT_W-1:0]          band_weight;
  modport source(output valid, first_real, first_imag, second_real, second_imag,
                 band_weight, input ready);
  modport sink(input valid, first_real, first_imag, second_real, second_imag,
               band_weight, output ready);
endinterface

interface ncpb_out_if;
  import ncpb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] norm_real;
  logic signed [OUT_W-1:0] norm_imag;
  modport source(output valid, norm_real, norm_imag, input ready);
  modport sink(input valid, norm_real, norm_imag, output ready);
endinterface

// File: rtl/ncpb_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
module ncpb_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [ncpb_pkg::SUM_W-1:0] x_i,
  input  ncpb_pkg::ncpb_side_t       side_i,
  output logic                       valid_o,
  output logic [ncpb_pkg::MAG_W-1:0] mag_o,
  output ncpb_pkg::ncpb_side_t       side_o
);
  import ncpb_pkg::*;

  logic             v_q    [NSQ+1];
  logic [SUM_W-1:0] x_q    [NSQ+1];
  logic [SQR_W-1:0] res_q  [NSQ+1];
  ncpb_side_t       side_q [NSQ+1];

  assign v_q[0]    = valid_i;
  assign x_q[0]    = x_i;
  assign res_q[0]  = '0;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < NSQ; k++) begin : g_stage
    localparam logic [SQR_W-1:0] BitK = SQR_W'(1) << (2 * (NSQ - 1 - k));
    logic [SQR_W-1:0] trial;
    logic             take;
    logic [SUM_W-1:0] x_d;
    logic [SQR_W-1:0] res_d;

    // one digit: subtract the trial value when it fits
    always_comb begin
      trial = res_q[k] + BitK;
      take  = {1'b0, x_q[k]} >= trial;
      if (take) begin
        x_d   = x_q[k] - trial[SUM_W-1:0];
        res_d = (res_q[k] >> 1) + BitK;
      end else begin
        x_d   = x_q[k];
        res_d = res_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k+1]    <= x_d;
        res_q[k+1]  <= res_d;
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[NSQ];
  assign mag_o   = res_q[NSQ][MAG_W-1:0];
  assign side_o  = side_q[NSQ];

endmodule

// File: rtl/ncpb_div.sv
// Pipelined restoring divider for both parts, rounding half up, one quotient bit per stage.
module ncpb_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [ncpb_pkg::NUM_W-1:0] num_r_i,
  input  logic [ncpb_pkg::NUM_W-1:0] num_i_i,
  input  logic [ncpb_pkg::MAG_W-1:0] mag_i,
  input  ncpb_pkg::ncpb_flag_t       flags_i,
  output logic                       valid_o,
  output logic [ncpb_pkg::QW-1:0]    q_r_o,
  output logic [ncpb_pkg::QW-1:0]    q_i_o,
  output ncpb_pkg::ncpb_flag_t       flags_o
);
  import ncpb_pkg::*;

  logic             v_q     [QW+1];
  logic [DW-1:0]    rem_r_q [QW+1];
  logic [DW-1:0]    rem_i_q [QW+1];
  logic [DEN_W-1:0] den_q   [QW+1];
  logic [QW-1:0]    q_r_q   [QW+1];
  logic [QW-1:0]    q_i_q   [QW+1];
  ncpb_flag_t       fl_q    [QW+1];

  logic [DEN_W-1:0] den;
  logic [DW-1:0]    half;

  // dividend = num + den/2 so that truncation rounds half up
  assign den  = DEN_W'(mag_i) << DEN_SH;
  assign half = DW'(den >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_r_q[0] <= (DW'(num_r_i) << NUM_SH) + half;
      rem_i_q[0] <= (DW'(num_i_i) << NUM_SH) + half;
      den_q[0]   <= den;
      q_r_q[0]   <= '0;
      q_i_q[0]   <= '0;
      fl_q[0]    <= flags_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] t;
    logic          ge_r;
    logic          ge_i;

    // compare both remainders against the shifted divisor
    always_comb begin
      t    = DW'(den_q[k]) << (QW - 1 - k);
      ge_r = rem_r_q[k] >= t;
      ge_i = rem_i_q[k] >= t;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r_q[k+1] <= ge_r ? rem_r_q[k] - t : rem_r_q[k];
        rem_i_q[k+1] <= ge_i ? rem_i_q[k] - t : rem_i_q[k];
        q_r_q[k+1]   <= {q_r_q[k][QW-2:0], ge_r};
        q_i_q[k+1]   <= {q_i_q[k][QW-2:0], ge_i};
        den_q[k+1]   <= den_q[k];
        fl_q[k+1]    <= fl_q[k];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign q_r_o   = q_r_q[QW];
  assign q_i_o   = q_i_q[QW];
  assign flags_o = fl_q[QW];

endmodule

// File: rtl/normalized_cross_power_bin.sv
// Normalized cross power bin: takes one spectrum bin pair and a band weight per cycle and
// returns weight * conj(A)*B / |conj(A)*B| in Q1.15, saturated to +/-32767, zero for a zero
// cross power. Fully pipelined: one request per cycle while not stalled, through the front
// stages, the one-bit-per-stage square root (31 stages), the divider (18 stages) and the
// output register. The whole pipeline stalls together while a finished result waits in it.
module normalized_cross_power_bin (
  input  logic      clk_i,
  input  logic      rst_ni,
  ncpb_in_if.sink   bin_i,
  ncpb_out_if.source res_o
);
  import ncpb_pkg::*;

  logic en;
  logic out_v_q;

  assign en          = !out_v_q || res_o.ready;
  assign bin_i.ready = en;

  // Stage 1: four partial products
  logic                     v1_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [WT_W-1:0]          w1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= bin_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_rr_q <= bin_i.first_real * bin_i.second_real;
      p_ii_q <= bin_i.first_imag * bin_i.second_imag;
      p_ri_q <= bin_i.first_real * bin_i.second_imag;
      p_ir_q <= bin_i.first_imag * bin_i.second_real;
      w1_q   <= bin_i.band_weight;
    end
  end

  // Stage 2: cross power in sign-magnitude form
  logic signed [CPX_W-1:0] cr, ci;
  logic                    v2_q, neg_r2_q, neg_i2_q;
  logic [CMAG_W-1:0]       mr2_q, mi2_q;
  logic [WT_W-1:0]         w2_q;

  assign cr = CPX_W'(p_rr_q) + CPX_W'(p_ii_q);
  assign ci = CPX_W'(p_ri_q) - CPX_W'(p_ir_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_r2_q <= cr[CPX_W-1];
      neg_i2_q <= ci[CPX_W-1];
      mr2_q    <= cr[CPX_W-1] ? CMAG_W'(-cr) : CMAG_W'(cr);
      mi2_q    <= ci[CPX_W-1] ? CMAG_W'(-ci) : CMAG_W'(ci);
      w2_q     <= w1_q;
    end
  end

  // Stage 3: normalize the larger part into [2^29, 2^30)
  logic [CMAG_W-1:0]        m2;
  logic [POS_W-1:0]         msb;
  logic [SH_W-1:0]          rsh, lsh;
  logic                     up;
  logic [CMAG_W+NRM_W-1:0]  xr, xi;
  logic                     v3_q, zero3_q, neg_r3_q, neg_i3_q;
  logic [NRM_W-1:0]         r3_q, i3_q;
  logic [WT_W-1:0]          w3_q;

  always_comb begin
    m2  = (mr2_q > mi2_q) ? mr2_q : mi2_q;
    msb = '0;
    for (int b = 0; b < CMAG_W; b++) begin
      if (m2[b]) msb = POS_W'(b);
    end
    up  = SH_W'(msb) > SH_W'(NRM_MSB);
    rsh = SH_W'(msb) - SH_W'(NRM_MSB);
    lsh = SH_W'(NRM_MSB) - SH_W'(msb);
    if (up) begin
      xr = (CMAG_W+NRM_W)'(mr2_q) >> rsh;
      xi = (CMAG_W+NRM_W)'(mi2_q) >> rsh;
    end else begin
      xr = (CMAG_W+NRM_W)'(mr2_q) << lsh;
      xi = (CMAG_W+NRM_W)'(mi2_q) << lsh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero3_q  <= (m2 == '0);
      neg_r3_q <= neg_r2_q;
      neg_i3_q <= neg_i2_q;
      r3_q     <= xr[NRM_W-1:0];
      i3_q     <= xi[NRM_W-1:0];
      w3_q     <= w2_q;
    end
  end

  // Stage 4: squares and weighted parts
  logic             v4_q;
  logic [SQ_W-1:0]  sq_r4_q, sq_i4_q;
  ncpb_side_t       side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_r4_q             <= SQ_W'(r3_q) * SQ_W'(r3_q);
      sq_i4_q             <= SQ_W'(i3_q) * SQ_W'(i3_q);
      side4_q.num_r       <= NUM_W'(r3_q) * NUM_W'(w3_q);
      side4_q.num_i       <= NUM_W'(i3_q) * NUM_W'(w3_q);
      side4_q.flags.zero  <= zero3_q;
      side4_q.flags.neg_r <= neg_r3_q;
      side4_q.flags.neg_i <= neg_i3_q;
    end
  end

  // Stage 5: sum of squares
  logic             v5_q;
  logic [SUM_W-1:0] sum5_q;
  ncpb_side_t       side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum5_q  <= SUM_W'(sq_r4_q) + SUM_W'(sq_i4_q);
      side5_q <= side4_q;
    end
  end

  // Magnitude
  logic             sq_v;
  logic [MAG_W-1:0] sq_mag;
  ncpb_side_t       sq_side;

  ncpb_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .x_i     (sum5_q),
    .side_i  (side5_q),
    .valid_o (sq_v),
    .mag_o   (sq_mag),
    .side_o  (sq_side)
  );

  // Division by the magnitude
  logic          dv_v;
  logic [QW-1:0] q_r, q_i;
  ncpb_flag_t    dv_fl;

  ncpb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .num_r_i (sq_side.num_r),
    .num_i_i (sq_side.num_i),
    .mag_i   (sq_mag),
    .flags_i (sq_side.flags),
    .valid_o (dv_v),
    .q_r_o   (q_r),
    .q_i_o   (q_i),
    .flags_o (dv_fl)
  );

  // Output register: saturate, apply sign, force zero
  logic [QW-1:0]    sat_r, sat_i;
  logic [OUT_W-1:0] o_r, o_i;
  logic [OUT_W-1:0] out_r_q, out_i_q;

  always_comb begin
    sat_r = (q_r > LIMIT) ? LIMIT : q_r;
    sat_i = (q_i > LIMIT) ? LIMIT : q_i;
    o_r   = dv_fl.neg_r ? OUT_W'(-sat_r) : OUT_W'(sat_r);
    o_i   = dv_fl.neg_i ? OUT_W'(-sat_i) : OUT_W'(sat_i);
    if (dv_fl.zero) begin
      o_r = '0;
      o_i = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_r_q <= o_r;
      out_i_q <= o_i;
    end
  end

  assign res_o.valid     = out_v_q;
  assign res_o.norm_real = out_r_q;
  assign res_o.norm_imag = out_i_q;

`ifndef ASSERT_OFF
  // normalization leaves the larger part with its top bit set
  a_norm_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !zero3_q) |-> (r3_q[NRM_MSB] || i3_q[NRM_MSB]))
    else $error("normalized part out of range");

  // magnitude of a nonzero bin is at least the normalized floor
  a_mag_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_v && !sq_side.flags.zero) |-> sq_mag[NRM_MSB +: 2] != 2'b00)
    else $error("magnitude below normalized range");

  // saturation never yields the most negative code
  a_no_min_r: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.norm_real != {1'b1, {OUT_FRAC{1'b0}}}))
    else $error("real result outside saturation range");

  a_no_min_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.norm_imag != {1'b1, {OUT_FRAC{1'b0}}}))
    else $error("imaginary result outside saturation range");
`endif

endmodule

// File: sim/tb_normalized_cross_power_bin.sv
// Testbench: normalized cross power bin against a bit-exact predictor, random idling on both sides.
module tb_normalized_cross_power_bin;
  import ncpb_pkg::*;

  typedef struct {
    logic [SPEC_W-1:0] ar, ai, br, bi;
    logic [WT_W-1:0]   wt;
  } bin_req_t;

  typedef struct {
    logic [OUT_W-1:0] re, im;
  } norm_res_t;

  logic clk_i;
  logic rst_ni;
  ncpb_in_if  bin_if ();
  ncpb_out_if res_if ();

  normalized_cross_power_bin dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bin_i  (bin_if.sink),
    .res_o  (res_if.source)
  );

  bin_req_t  pending_bins[$];
  norm_res_t expected_norm[$];
  int        mismatches;
  int        cycle_cnt;
  int        send_gap;
  int        stall_gap;
  bit        stim_done;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sign-magnitude view of a signed spectrum field
  function automatic void to_sm(input logic [SPEC_W-1:0] v, output logic [63:0] mag,
                                output bit neg);
    neg = v[SPEC_W-1];
    mag = neg ? 64'(-$signed({1'b1, v})) : 64'(v);
    if (neg) mag = 64'(~v) + 64'd1;
    mag = mag & ((64'd1 << SPEC_W) - 1);
    if (neg && mag == 0) mag = 64'd1 << (SPEC_W - 1);
  endfunction

  // Signed sum of two sign-magnitude products
  function automatic void sm_sum(input logic [63:0] am, input bit an, input logic [63:0] bm,
                                 input bit bn, output logic [63:0] rm, output bit rn);
    if (an == bn) begin
      rm = am + bm; rn = an;
    end else if (am >= bm) begin
      rm = am - bm; rn = an;
    end else begin
      rm = bm - am; rn = bn;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Weighted, rounded, saturated quotient of one part
  function automatic logic [OUT_W-1:0] scale_norm(input logic [63:0] part,
      input logic [63:0] wt, input logic [63:0] mag, input bit neg);
    logic [63:0] num, den, q;
    num = part * wt;
    den = mag;
    if (OUT_FRAC >= WT_FRAC) num <<= (OUT_FRAC - WT_FRAC);
    else den <<= (WT_FRAC - OUT_FRAC);
    q = (num + (den >> 1)) / den;
    if (q > (64'd1 << OUT_FRAC) - 1) q = (64'd1 << OUT_FRAC) - 1;
    if (neg) q = 64'd0 - q;
    return q[OUT_W-1:0];
  endfunction

  // conj(A)*B scaled to unit magnitude, times the band weight
  function automatic norm_res_t predict_norm(input bin_req_t b);
    norm_res_t   r;
    logic [63:0] arm, aim, brm, bim, crm, cim, tm, um, pr, pi, m, mag;
    bit          arn, ain, brn, bin, crn, cin, tn, un;
    to_sm(b.ar, arm, arn);
    to_sm(b.ai, aim, ain);
    to_sm(b.br, brm, brn);
    to_sm(b.bi, bim, bin);
    tm = arm * brm; tn = (tm != 0) && (arn != brn);
    um = aim * bim; un = (um != 0) && (ain != bin);
    sm_sum(tm, tn, um, un, crm, crn);
    tm = arm * bim; tn = (tm != 0) && (arn != bin);
    um = aim * brm; un = (um != 0) && !(ain != brn);
    sm_sum(tm, tn, um, un, cim, cin);
    pr = crm; pi = cim;
    m = (pr > pi) ? pr : pi;
    if (m == 0) begin
      r.re = '0; r.im = '0;
      return r;
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1; pr >>= 1; pi >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1; pr <<= 1; pi <<= 1;
    end
    mag = int_sqrt(pr * pr + pi * pi);
    r.re = scale_norm(pr, 64'(b.wt), mag, crn);
    r.im = scale_norm(pi, 64'(b.wt), mag, cin);
    return r;
  endfunction

  function automatic logic [SPEC_W-1:0] rand_spec();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(SPEC_W-1){1'b0}}};
      1: return {1'b0, {(SPEC_W-1){1'b1}}};
      2: return SPEC_W'($signed($urandom_range(0, 8)) - 4);
      3: return SPEC_W'($urandom_range(0, 255)) ^ {SPEC_W{$urandom_range(0, 1) == 1}};
      default: return SPEC_W'($urandom);
    endcase
  endfunction

  function automatic logic [WT_W-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return WT_W'(65536);
      1: return '0;
      2: return WT_W'($urandom);
      default: return WT_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic add_bin(input logic [SPEC_W-1:0] ar, ai, br, bi, input logic [WT_W-1:0] wt);
    bin_req_t b;
    b.ar = ar; b.ai = ai; b.br = br; b.bi = bi; b.wt = wt;
    pending_bins = {pending_bins, b};
  endtask

  function automatic int rand_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Stimulus
  initial begin
    logic [SPEC_W-1:0] mx, mn;
    mx = {1'b0, {(SPEC_W-1){1'b1}}};
    mn = {1'b1, {(SPEC_W-1){1'b0}}};
    // zero cross power
    add_bin('0, '0, '0, '0, WT_W'(65536));
    add_bin(mx, mn, '0, '0, WT_W'(65536));
    add_bin('0, '0, mn, mx, WT_W'(65536));
    // field extremes, a zero weight and unit values
    add_bin(mx, mx, mx, mx, WT_W'(65536));
    add_bin(mn, mn, mn, mn, WT_W'(65536));
    add_bin(mn, mx, mx, mn, WT_W'(65536));
    add_bin(mx, mn, mn, mx, '0);
    add_bin(mn, '0, mn, '0, WT_W'(65536));
    add_bin('0, mn, mn, '0, WT_W'(65536));
    add_bin(SPEC_W'(1), '0, SPEC_W'(1), '0, WT_W'(65536));
    add_bin(SPEC_W'(1), '0, '0, SPEC_W'(1), WT_W'(32768));
    add_bin(SPEC_W'(1), SPEC_W'(1), SPEC_W'(1), '0, WT_W'(65536));
    add_bin({SPEC_W{1'b1}}, '0, SPEC_W'(1), '0, WT_W'(65536));
    // weights above one saturate, then the smallest weight
    add_bin(SPEC_W'(3), SPEC_W'(4), SPEC_W'(5), '0, {WT_W{1'b1}});
    add_bin(SPEC_W'(1), SPEC_W'(1), SPEC_W'(1), SPEC_W'(1), WT_W'(100000));
    add_bin(SPEC_W'(12345), mn, mx, SPEC_W'(777), WT_W'(1));
    for (int i = 0; i < 700; i++)
      add_bin(rand_spec(), rand_spec(), rand_spec(), rand_spec(), rand_weight());
  end

  // Reset
  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Request driver: the front of the queue is the request on the bus
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_if.valid       <= 1'b0;
      bin_if.first_real  <= '0;
      bin_if.first_imag  <= '0;
      bin_if.second_real <= '0;
      bin_if.second_imag <= '0;
      bin_if.band_weight <= '0;
      send_gap           <= 0;
    end else if (!bin_if.valid || bin_if.ready) begin
      if (bin_if.valid) begin
        expected_norm = {expected_norm, predict_norm(pending_bins.pop_front())};
      end
      if (send_gap > 0 || pending_bins.size() == 0) begin
        bin_if.valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        bin_req_t b;
        b = pending_bins[0];
        bin_if.valid       <= 1'b1;
        bin_if.first_real  <= b.ar;
        bin_if.first_imag  <= b.ai;
        bin_if.second_real <= b.br;
        bin_if.second_imag <= b.bi;
        bin_if.band_weight <= b.wt;
        send_gap           <= rand_gap();
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_gap    <= 0;
      mismatches   <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_norm.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %0d %0d", res_if.norm_real,
                                        res_if.norm_imag);
          mismatches <= mismatches + 1;
        end else begin
          norm_res_t e;
          e = expected_norm.pop_front();
          if (e.re !== res_if.norm_real || e.im !== res_if.norm_imag) begin
            if (mismatches < 10)
              $display("mismatch: expected re %0d im %0d, got re %0d im %0d",
                       $signed(e.re), $signed(e.im), res_if.norm_real, res_if.norm_imag);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (stall_gap > 0) begin
        res_if.ready <= 1'b0;
        stall_gap    <= stall_gap - 1;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_gap <= rand_gap();
      end
    end
  end

  // End of run and timeout
  initial begin
    cycle_cnt = 0;
    @(posedge rst_ni);
    while (pending_bins.size() != 0 || bin_if.valid || expected_norm.size() != 0) begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > 400000) begin
        $display("simulation failed");
        $finish;
      end
    end
    repeat (120) @(posedge clk_i);
    if (mismatches == 0 && expected_norm.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
